[hdl/magic_word_frame_deframer_unit_assert.svh]
// Assertion macros used by the deframer core (mwfd_core).
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef MAGIC_WORD_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define MAGIC_WORD_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define MWFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mwfd: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define MWFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mwfd: next-cycle check failed");

`endif

[hdl/mwfd_pkg.sv]
// Shared types and constants for the magic-word frame deframer.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package mwfd_pkg;

  // Header layout and register reset values
  localparam logic [3:0]  HDR_BYTES     = 4'd8;
  localparam logic [31:0] MIN_FRAME_LEN = 32'd9;
  localparam logic [31:0] RESET_MAGIC   = 32'd1234567890;
  localparam logic [31:0] RESET_MAX_LEN = 32'd1000000;

  // Configuration port
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_WORD    = 2'd0,
    CFG_MAX_FRAME_LEN = 2'd1
  } cfg_idx_t;

  // Result kind codes
  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_DISCARD = 1'b1
  } kind_t;

  // Byte held in the input stage
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } item_t;

  // Result produced by the core for one byte
  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

[hdl/mwfd_in_stage.sv]
// Input register stage of the deframer: holds one received byte.
// Depends on mwfd_pkg (item_t).
`default_nettype none

module mwfd_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          adv,
  output mwfd_pkg::item_t    item,
  output logic               fire
);
  import mwfd_pkg::*;

  logic       vld_r, vld_nxt;
  logic [7:0] data_r, data_nxt;

  // Held byte leaves when the core can take it
  assign fire     = vld_r && adv;
  assign in_stall = vld_r && !adv;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (!in_stall) begin
      vld_nxt  = in_valid;
      data_nxt = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign item = '{vld: vld_r, data: data_r};

endmodule

`default_nettype wire

[hdl/mwfd_core.sv]
// Deframer core: config registers, header window, hunt/payload state.
// Depends on mwfd_pkg and the assertion macro header.
`default_nettype none
`include "magic_word_frame_deframer_unit_assert.svh"

module mwfd_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [mwfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_data,
  input  wire mwfd_pkg::item_t                  item,
  input  wire logic                             fire,
  output mwfd_pkg::res_t                        res
);
  import mwfd_pkg::*;

  logic [31:0] magic_r, magic_nxt;
  logic [31:0] max_len_r, max_len_nxt;
  logic [63:0] win_r, win_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic        pay_r, pay_nxt;
  logic [31:0] rem_r, rem_nxt;

  logic [63:0] win_ins;
  logic [3:0]  fill_inc;
  logic [31:0] hdr_len;
  logic        hdr_ok;
  logic        fin;

  // Config writes; unknown indexes are dropped
  always_comb begin
    magic_nxt   = magic_r;
    max_len_nxt = max_len_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAGIC_WORD:    magic_nxt   = cfg_data;
        CFG_MAX_FRAME_LEN: max_len_nxt = cfg_data;
        default:           ;
      endcase
    end
  end

  // New byte dropped into the first free window slot
  always_comb begin
    win_ins = win_r;
    for (int i = 0; i < 8; i++) begin
      if (fill_r[2:0] == 3'(i)) begin
        win_ins[8*i +: 8] = item.data;
      end
    end
  end

  assign fill_inc = fill_r + 4'd1;
  assign hdr_len  = win_ins[63:32];
  assign hdr_ok   = (win_ins[31:0] == magic_r) && (hdr_len >= MIN_FRAME_LEN) &&
                    (hdr_len <= max_len_r);
  assign fin      = (rem_r <= 32'd1);

  // Per-byte state update and result
  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    pay_nxt  = pay_r;
    rem_nxt  = rem_r;
    res      = '{vld: 1'b0, kind: KIND_PAYLOAD, data: item.data, last: 1'b0};
    if (pay_r) begin
      res.vld  = 1'b1;
      res.last = fin;
      if (fin) begin
        pay_nxt  = 1'b0;
        rem_nxt  = 32'd0;
        win_nxt  = 64'd0;
        fill_nxt = 4'd0;
      end else begin
        rem_nxt = rem_r - 32'd1;
      end
    end else if (fill_inc < HDR_BYTES) begin
      // header still filling
      win_nxt  = win_ins;
      fill_nxt = fill_inc;
    end else if (hdr_ok) begin
      pay_nxt  = 1'b1;
      rem_nxt  = hdr_len - 32'(HDR_BYTES);
      win_nxt  = 64'd0;
      fill_nxt = 4'd0;
    end else begin
      // bad header: drop oldest byte, slide by one
      res.vld  = 1'b1;
      res.kind = KIND_DISCARD;
      res.data = win_ins[7:0];
      win_nxt  = {8'd0, win_ins[63:8]};
      fill_nxt = HDR_BYTES - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= RESET_MAGIC;
      max_len_r <= RESET_MAX_LEN;
      win_r     <= 64'd0;
      fill_r    <= 4'd0;
      pay_r     <= 1'b0;
      rem_r     <= 32'd0;
    end else begin
      magic_r   <= magic_nxt;
      max_len_r <= max_len_nxt;
      if (fire) begin
        win_r  <= win_nxt;
        fill_r <= fill_nxt;
        pay_r  <= pay_nxt;
        rem_r  <= rem_nxt;
      end
    end
  end

  // Checks
  `MWFD_ASSERT_IMP(a_pay_win_empty, pay_r, (fill_r == 4'd0) && (win_r == 64'd0))
  `MWFD_ASSERT_IMP(a_pay_rem_live, pay_r, rem_r != 32'd0)
  `MWFD_ASSERT_IMP(a_discard_full, fire && res.vld && (res.kind == KIND_DISCARD),
                   fill_r == 4'd7)
  `MWFD_ASSERT_NXT(a_last_ends_frame, fire && pay_r && res.last, !pay_r && (fill_r == 4'd0))

endmodule

`default_nettype wire

[hdl/mwfd_out_stage.sv]
// Output register stage of the deframer: holds one result transfer.
// Depends on mwfd_pkg (res_t, kind_t).
`default_nettype none

module mwfd_out_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mwfd_pkg::res_t  res,
  input  wire logic            fire,
  output logic                 adv,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_kind,
  output logic [7:0]           out_data,
  output logic                 out_last
);
  import mwfd_pkg::*;

  logic       vld_r, vld_nxt;
  res_t       res_r, res_nxt;
  logic       load;

  // Slot free when empty or being drained this cycle
  assign adv  = !vld_r || !out_stall;
  assign load = fire && res.vld;

  always_comb begin
    vld_nxt = vld_r && out_stall;
    res_nxt = res_r;
    if (load) begin
      vld_nxt = 1'b1;
      res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = vld_r;
  assign out_kind  = res_r.kind;
  assign out_data  = res_r.data;
  assign out_last  = res_r.last;

endmodule

`default_nettype wire

[hdl/magic_word_frame_deframer_unit.sv]
// Magic-word frame deframer: byte stream in, payload/discard bytes out.
// Channels: in_* carries received bytes, out_* carries results (kind, data,
// last); both use valid/stall, a transfer happens when valid is high and
// stall is low. cfg_* writes register 0 (magic word) or 1 (max frame length);
// other indexes ignored; write only while the block is idle (not enforced).
// Each byte passes an input register, then the header/payload logic, then
// the output register, which drives out_valid. One byte is taken per cycle
// while out_stall is low; the header window and byte counter are updated
// as each byte passes the core.
// Bytes that only fill the header, and the byte completing a good header,
// give no result. A bad header reports its oldest byte as discarded.
// Reset (rst_n low, synchronous) empties both registers, clears the window
// and hunt state, and reloads magic 1234567890 and max length 1000000.
// When out_stall holds, the output register keeps its result, the input
// register fills and then in_stall rises in the same cycle; nothing is lost.
// Depends on mwfd_pkg, mwfd_in_stage, mwfd_core, mwfd_out_stage.
`default_nettype none

module magic_word_frame_deframer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [mwfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_kind,
  output logic [7:0]                            out_data,
  output logic                                  out_last
);
  import mwfd_pkg::*;

  item_t item;
  res_t  res;
  logic  fire;
  logic  adv;

  mwfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .item       (item),
    .fire       (fire)
  );

  mwfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .fire      (fire),
    .res       (res)
  );

  mwfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .fire      (fire),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_data  (out_data),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

[test/magic_word_frame_deframer_checker.sv]
`timescale 1ns / 1ps
// Checker for the magic-word frame deframer: keeps its own copy of the deframer
// state, predicts each result and compares it with the output transfers.
// Depends on mwfd_pkg for the kind codes, register indexes and header constants.

module magic_word_frame_deframer_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mwfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_kind,
  input  logic [7:0]                     out_data,
  input  logic                           out_last,
  output int                             mismatch_count,
  output int                             results_due
);
  import mwfd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } deframed_t;

  // Predicted register contents
  logic [31:0] sync_word;
  logic [31:0] frame_len_limit;

  // Predicted deframer state
  logic [63:0] hdr_window;
  logic [3:0]  hdr_fill;
  logic        in_frame;
  logic [31:0] bytes_left;

  deframed_t pending_results[$];
  int        errors;

  // Advance the deframer by one received byte; queue the result it gives
  task automatic deframe_byte(input logic [7:0] rx);
    logic [31:0] head;
    logic [31:0] len;
    deframed_t   res;
    if (in_frame) begin
      res.kind = KIND_PAYLOAD;
      res.data = rx;
      res.last = (bytes_left <= 32'd1);
      pending_results.push_back(res);
      if (res.last) begin
        in_frame   = 1'b0;
        bytes_left = '0;
        hdr_window = '0;
        hdr_fill   = '0;
      end else begin
        bytes_left = bytes_left - 32'd1;
      end
    end else begin
      hdr_window = hdr_window | ({56'd0, rx} << (8 * hdr_fill));
      hdr_fill   = hdr_fill + 4'd1;
      if (hdr_fill >= HDR_BYTES) begin
        head = hdr_window[31:0];
        len  = hdr_window[63:32];
        if (head == sync_word && len >= MIN_FRAME_LEN && len <= frame_len_limit) begin
          // good header: no result, payload mode starts
          in_frame   = 1'b1;
          bytes_left = len - 32'(HDR_BYTES);
          hdr_window = '0;
          hdr_fill   = '0;
        end else begin
          // bad header: oldest byte goes out as discarded, window slides
          res.kind = KIND_DISCARD;
          res.data = hdr_window[7:0];
          res.last = 1'b0;
          pending_results.push_back(res);
          hdr_window = hdr_window >> 8;
          hdr_fill   = HDR_BYTES - 4'd1;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    deframed_t oldest;
    if (!rst_n) begin
      sync_word       = RESET_MAGIC;
      frame_len_limit = RESET_MAX_LEN;
      hdr_window      = '0;
      hdr_fill        = '0;
      in_frame        = 1'b0;
      bytes_left      = '0;
      errors          = 0;
      pending_results.delete();
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAGIC_WORD:    sync_word       = cfg_data;
          CFG_MAX_FRAME_LEN: frame_len_limit = cfg_data;
          default: ;
        endcase
      end

      // input transfer: predict
      if (in_valid && !in_stall)
        deframe_byte(in_rx_byte);

      // output transfer: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t deframer: unexpected result kind=%0b data=%02h last=%0b",
                     $realtime, out_kind, out_data, out_last);
        end else begin
          oldest = pending_results[0];
          pending_results.delete(0);
          if (oldest.kind !== out_kind || oldest.data !== out_data ||
              oldest.last !== out_last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t deframer: expected %0b/%02h/%0b, got %0b/%02h/%0b",
                       $realtime, oldest.kind, oldest.data, oldest.last,
                       out_kind, out_data, out_last);
          end
        end
      end
    end
    mismatch_count <= errors;
    results_due    <= pending_results.size();
  end

endmodule

[test/tb_magic_word_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// Testbench top for magic_word_frame_deframer_unit: drives byte streams of good,
// broken and noisy frames over several register settings and gives the verdict.
// Depends on mwfd_pkg, the deframer RTL and magic_word_frame_deframer_checker.

module tb_magic_word_frame_deframer_unit;
  import mwfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]          cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic [7:0]           in_rx_byte = '0;
  logic                 out_stall  = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_kind;
  logic [7:0]           out_data;
  logic                 out_last;

  int mismatch_count;
  int results_due;
  int idle_cycles = 0;
  int bytes_sent  = 0;

  // Stimulus controls
  bit          tx_gaps     = 1'b1;
  bit          rx_gaps     = 1'b1;
  bit          holdoff_req = 1'b0;
  logic [31:0] cur_magic   = RESET_MAGIC;
  logic [31:0] cur_max     = RESET_MAX_LEN;

  magic_word_frame_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  magic_word_frame_deframer_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data       (out_data),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        n = HOLDOFF_CYCLES;
      end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 17);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One byte transfer, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    if (tx_gaps && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Header bytes, little-endian magic then length
  task automatic send_header(input logic [31:0] magic, input logic [31:0] len);
    logic [63:0] hdr;
    hdr = {len, magic};
    for (int i = 0; i < 8; i++)
      send_byte(hdr[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] magic, input logic [31:0] len,
                            input int body);
    send_header(magic, len);
    repeat (body) send_byte($urandom_range(0, 255));
  endtask

  // Stop offering, wait for every predicted result, let the pipeline settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers, then poke the unused indexes
  task automatic program_regs(input logic [31:0] magic, input logic [31:0] max_len);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAGIC_WORD;
    cfg_data  <= magic;
    @(posedge clk);
    cfg_index <= CFG_MAX_FRAME_LEN;
    cfg_data  <= max_len;
    @(posedge clk);
    cfg_index <= CFG_IDX_SPARE_A;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_index <= CFG_IDX_SPARE_B;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_magic = magic;
    cur_max   = max_len;
  endtask

  // Mostly good frames; some noise and some broken headers
  task automatic send_random_sequence();
    int          pick;
    int          flavor;
    logic [31:0] span;
    logic [31:0] len;
    logic [31:0] magic;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      if (cur_max < MIN_FRAME_LEN) begin
        // tiny limit: even the shortest frame gets rejected
        len = MIN_FRAME_LEN;
      end else begin
        span = cur_max - MIN_FRAME_LEN;
        if ($urandom_range(0, 15) == 0) begin
          if (span > 32'd250) span = 32'd250;
        end else if (span > 32'd40) begin
          span = 32'd40;
        end
        len = MIN_FRAME_LEN + $urandom_range(0, span);
      end
      send_frame(cur_magic, len, int'(len - 32'(HDR_BYTES)));
    end else if (pick < 17) begin
      repeat ($urandom_range(1, 12)) send_byte($urandom_range(0, 255));
    end else begin
      magic  = cur_magic;
      flavor = $urandom_range(0, 2);
      if (flavor == 0) begin
        magic = cur_magic ^ (32'd1 << $urandom_range(0, 31));
        len   = MIN_FRAME_LEN + $urandom_range(0, 20);
      end else if (flavor == 1 || cur_max == 32'hFFFF_FFFF) begin
        len = $urandom_range(0, 8);
      end else begin
        case ($urandom_range(0, 2))
          0:       len = cur_max + 32'd1;
          1:       len = 32'hFFFF_FFFF;
          default: len = cur_max + 32'd1 + ($urandom() % (32'hFFFF_FFFF - cur_max));
        endcase
      end
      send_frame(magic, len, $urandom_range(0, 12));
    end
  endtask

  task automatic run_phase(input logic [31:0] magic, input logic [31:0] max_len,
                           input int nbytes, input bit gaps, input bit holdoff);
    int stop_at;
    drain_and_settle();
    program_regs(magic, max_len);
    tx_gaps     = gaps;
    rx_gaps     = gaps;
    holdoff_req = holdoff;
    stop_at     = bytes_sent + nbytes;
    while (bytes_sent < stop_at) send_random_sequence();
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: shortest good frame, then a short length
    send_header(RESET_MAGIC, MIN_FRAME_LEN);
    send_byte(8'hFF);
    send_header(RESET_MAGIC, 32'd8);
    // Window slides past the leftovers onto a good header
    send_header(RESET_MAGIC, 32'd10);
    send_byte(8'h00);
    // Lower the limit in mid-frame; the running frame is unaffected
    drain_and_settle();
    program_regs(RESET_MAGIC, MIN_FRAME_LEN);
    send_byte(8'h80);

    run_phase($urandom(), RESET_MAX_LEN, 400, 1'b1, 1'b1);
    run_phase(32'hFFFF_FFFF, 32'd64, 300, 1'b1, 1'b0);
    run_phase(32'h0000_0000, MIN_FRAME_LEN, 250, 1'b1, 1'b0);
    run_phase($urandom(), 32'd8, 80, 1'b1, 1'b0);
    run_phase($urandom(), 32'hFFFF_FFFF, 300, 1'b1, 1'b0);
    run_phase($urandom(), 32'd200, 200, 1'b0, 1'b0);

    drain_and_settle();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
